@@ design/akf_pkg.sv @@
// Shared types and constants for the two-state altitude Kalman filter.
// No dependencies; used by akf_arith and altitude_kalman_filter_2state.
`default_nettype none
package akf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int DT_W       = 21;
    localparam int FIELD_W    = 32;
    localparam int NOISE_W    = 31;
    localparam int IN_TDATA_W = 88;
    localparam int OUT_TDATA_W = 160;

    localparam logic [NOISE_W-1:0] NOISE_RESET = 31'd65536;

    localparam logic CFG_PROC_NOISE = 1'b0;
    localparam logic CFG_MEAS_NOISE = 1'b1;

    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_UPDATE  = 1'b1;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } akf_cmd_t;

endpackage
`default_nettype wire

@@ design/akf_arith.sv @@
// Shared multi-cycle multiply / divide unit; products are rounded, and both results saturate.
// Depends on akf_pkg (command struct and op codes).
`default_nettype none
module akf_arith #(
    parameter int WORD_BITS = akf_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEF,
    parameter int XW        = WORD_BITS + 2
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire akf_pkg::akf_cmd_t           cmd,
    input  wire logic signed [XW-1:0]        opa,
    input  wire logic signed [XW-1:0]        opb,
    output logic                             done,
    output logic signed [WORD_BITS-1:0]      result
);

    localparam int PW = 2 * XW;
    localparam int NW = XW + FRAC_BITS;
    localparam int DG = 4;
    localparam int MS = (XW + DG - 1) / DG;
    localparam int CW = $clog2(NW + 1);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_DIV  = 2'd2;
    localparam logic [1:0] A_FIN  = 2'd3;

    localparam logic [PW:0] HALF_R = (PW+1)'(1) << (FRAC_BITS - 1);
    localparam logic [PW:0] LIM_POS = (PW+1)'({(WORD_BITS-1){1'b1}});
    localparam logic [PW:0] LIM_NEG = LIM_POS + (PW+1)'(1);

    logic [1:0]     st_reg;
    logic [CW-1:0]  cnt_reg;
    logic           neg_reg;
    logic           op_reg;
    logic [PW-1:0]  acc_reg;
    logic [PW-1:0]  ash_reg;
    logic [XW-1:0]  bsh_reg;
    logic [XW-1:0]  rem_reg;

    logic [XW-1:0]  ma, mb;
    logic [XW:0]    sv;
    logic           ge;
    logic [PW:0]    mag_f, lim, mag_s;

    function automatic logic [XW-1:0] mag(input logic signed [XW-1:0] v);
        return v[XW-1] ? XW'(0) - XW'(v) : XW'(v);
    endfunction

    always_comb begin
        ma = mag(opa);
        mb = mag(opb);
        sv = {rem_reg, ash_reg[NW-1]};
        ge = sv >= {1'b0, bsh_reg};
        if (op_reg == akf_pkg::OP_MUL) begin
            mag_f = ((PW+1)'(acc_reg) + HALF_R) >> FRAC_BITS;
        end else if (bsh_reg == '0) begin
            mag_f = '0;
        end else begin
            mag_f = (PW+1)'(acc_reg);
        end
        lim   = neg_reg ? LIM_NEG : LIM_POS;
        mag_s = (mag_f > lim) ? lim : mag_f;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= A_IDLE;
            done   <= 1'b0;
        end else begin
            done <= 1'b0;
            unique case (st_reg)
                A_IDLE: begin
                    if (cmd.start) begin
                        neg_reg <= opa[XW-1] ^ opb[XW-1];
                        op_reg  <= cmd.op;
                        acc_reg <= '0;
                        rem_reg <= '0;
                        bsh_reg <= mb;
                        if (cmd.op == akf_pkg::OP_MUL) begin
                            ash_reg <= PW'(ma);
                            cnt_reg <= CW'(MS);
                            st_reg  <= A_MUL;
                        end else begin
                            ash_reg <= PW'(ma) << FRAC_BITS;
                            cnt_reg <= CW'(NW);
                            st_reg  <= A_DIV;
                        end
                    end
                end
                A_MUL: begin
                    acc_reg <= acc_reg + PW'(ash_reg * bsh_reg[DG-1:0]);
                    ash_reg <= ash_reg << DG;
                    bsh_reg <= bsh_reg >> DG;
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        st_reg <= A_FIN;
                    end
                end
                A_DIV: begin
                    rem_reg <= ge ? XW'(sv - {1'b0, bsh_reg}) : sv[XW-1:0];
                    acc_reg <= {acc_reg[PW-2:0], ge};
                    ash_reg <= ash_reg << 1;
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        st_reg <= A_FIN;
                    end
                end
                A_FIN: begin
                    result <= neg_reg ? WORD_BITS'(0) - mag_s[WORD_BITS-1:0]
                                      : mag_s[WORD_BITS-1:0];
                    done   <= 1'b1;
                    st_reg <= A_IDLE;
                end
                default: st_reg <= A_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ design/altitude_kalman_filter_2state.sv @@
// Two-state altitude / vertical-velocity Kalman filter, top level.
// Depends on akf_pkg and akf_arith (shared multiply / divide unit).
//
//   channel  direction  handshake            payload
//   s_       in         s_tvalid / s_tready  s_tuser mode, s_tdata dt, accel, range
//   m_       out        m_tvalid / m_tready  m_tdata alt, vel, P00, P01, P11
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Speed: set by the shared unit, at 4 multiplier bits a cycle and one quotient bit a cycle;
// a new item is taken only once the previous one has been committed.
// Reset: synchronous, active low; restores the state and both noise registers.
// Stalls: a finished result sits in the output register while the next item
// is taken; the block holds a new result until the previous one is taken.
`default_nettype none
module altitude_kalman_filter_2state #(
    parameter int FRAC_BITS = akf_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = akf_pkg::WORD_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [akf_pkg::IN_TDATA_W-1:0]     s_tdata,  // delta_t, accel_z, range_meas, pad
    input  wire logic                               s_tuser,  // mode
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [akf_pkg::OUT_TDATA_W-1:0]         m_tdata,  // altitude, velocity, var_alt,
                                                              // cov_alt_vel, var_vel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_index,
    input  wire logic [akf_pkg::NOISE_W-1:0]        cfg_data
);

    localparam int XW = ((WORD_BITS > 32) ? WORD_BITS : 32) + 2;
    localparam int SW = WORD_BITS + 4;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic signed [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] W_MAX =
        {{(SW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] W_MIN = ~W_MAX;
    localparam logic signed [WORD_BITS-1:0] ONE = WORD_BITS'(1) << FRAC_BITS;

    logic [1:0]                       state_reg;
    logic [2:0]                       step_reg;
    logic                             mode_reg;
    logic [akf_pkg::DT_W-1:0]         dt_reg;
    logic signed [31:0]               acc_in_reg;
    logic signed [31:0]               z_reg;
    logic [akf_pkg::NOISE_W-1:0]      q_reg, r_reg;
    logic signed [WORD_BITS-1:0]      alt_reg, vel_reg, p00_reg, p01_reg, p11_reg;
    logic signed [WORD_BITS-1:0]      tmp_reg [8];
    logic [akf_pkg::OUT_TDATA_W-1:0]  out_reg;

    logic signed [WORD_BITS-1:0]      alt_next, vel_next, p00_next, p01_next, p11_next;
    akf_pkg::akf_cmd_t                au_cmd;
    logic signed [XW-1:0]             opa, opb, dt_x, a_x, e_x, den_x;
    logic                             au_done;
    logic signed [WORD_BITS-1:0]      au_result;
    logic [2:0]                       last_step;

    function automatic logic signed [SW-1:0] ext(input logic signed [WORD_BITS-1:0] v);
        return SW'(v);
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_w(input logic signed [SW-1:0] v);
        if (v > W_MAX) return W_MAX[WORD_BITS-1:0];
        if (v < W_MIN) return W_MIN[WORD_BITS-1:0];
        return v[WORD_BITS-1:0];
    endfunction

    function automatic logic [31:0] o32(input logic signed [WORD_BITS-1:0] v);
        logic signed [63:0] x;
        x = 64'(v);
        if (x > 64'sd2147483647) return 32'h7fff_ffff;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    akf_arith #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .XW        (XW)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (au_cmd),
        .opa     (opa),
        .opb     (opb),
        .done    (au_done),
        .result  (au_result)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tdata   = out_reg;
    assign last_step = (mode_reg == akf_pkg::MODE_UPDATE) ? 3'd6 : 3'd7;

    always_comb begin
        dt_x  = XW'(dt_reg);
        a_x   = XW'(acc_in_reg);
        e_x   = XW'(z_reg) - XW'(alt_reg);
        den_x = XW'(p00_reg) + XW'(r_reg);
        au_cmd.start = (state_reg == ST_ISSUE);
        au_cmd.op    = akf_pkg::OP_MUL;
        opa = dt_x;
        opb = a_x;
        if (mode_reg == akf_pkg::MODE_PREDICT) begin
            case (step_reg)
                3'd0: begin opa = dt_x; opb = a_x; end
                3'd1: begin opa = dt_x; opb = dt_x; end
                3'd2: begin opa = XW'(tmp_reg[1]); opb = a_x; end
                3'd3: begin opa = HALF; opb = XW'(tmp_reg[2]); end
                3'd4: begin opa = dt_x; opb = XW'(vel_reg); end
                3'd5: begin opa = dt_x; opb = XW'(p11_reg); end
                3'd6: begin opa = dt_x; opb = XW'(p01_reg); end
                default: begin opa = dt_x; opb = XW'(tmp_reg[5]); end
            endcase
        end else begin
            case (step_reg)
                3'd0: begin au_cmd.op = akf_pkg::OP_DIV; opa = XW'(p00_reg); opb = den_x; end
                3'd1: begin au_cmd.op = akf_pkg::OP_DIV; opa = XW'(p01_reg); opb = den_x; end
                3'd2: begin opa = XW'(tmp_reg[0]); opb = e_x; end
                3'd3: begin opa = XW'(tmp_reg[1]); opb = e_x; end
                3'd4: begin opa = XW'(tmp_reg[0]); opb = XW'(p00_reg); end
                3'd5: begin opa = XW'(tmp_reg[0]); opb = XW'(p01_reg); end
                default: begin opa = XW'(tmp_reg[1]); opb = XW'(p01_reg); end
            endcase
        end
    end

    always_comb begin
        if (mode_reg == akf_pkg::MODE_PREDICT) begin
            alt_next = sat_w(ext(alt_reg) + ext(tmp_reg[4]) + ext(tmp_reg[3]));
            vel_next = sat_w(ext(vel_reg) + ext(tmp_reg[0]));
            p00_next = sat_w(ext(p00_reg) + (ext(tmp_reg[6]) <<< 1) + ext(tmp_reg[7])
                             + $signed(SW'(q_reg)));
            p01_next = sat_w(ext(p01_reg) + ext(tmp_reg[5]));
            p11_next = sat_w(ext(p11_reg) + $signed(SW'(q_reg)));
        end else begin
            alt_next = sat_w(ext(alt_reg) + ext(tmp_reg[2]));
            vel_next = sat_w(ext(vel_reg) + ext(tmp_reg[3]));
            p00_next = sat_w(ext(p00_reg) - ext(tmp_reg[4]));
            p01_next = sat_w(ext(p01_reg) - ext(tmp_reg[5]));
            p11_next = sat_w(ext(p11_reg) - ext(tmp_reg[6]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            m_tvalid  <= 1'b0;
            q_reg     <= akf_pkg::NOISE_RESET;
            r_reg     <= akf_pkg::NOISE_RESET;
            alt_reg   <= '0;
            vel_reg   <= '0;
            p00_reg   <= ONE;
            p01_reg   <= '0;
            p11_reg   <= ONE;
        end else begin
            if (state_reg == ST_DONE && (!m_tvalid || m_tready)) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_index == akf_pkg::CFG_PROC_NOISE) begin
                    q_reg <= cfg_data;
                end else begin
                    r_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg   <= s_tuser;
                        dt_reg     <= s_tdata[20:0];
                        acc_in_reg <= s_tdata[52:21];
                        z_reg      <= s_tdata[84:53];
                        step_reg   <= '0;
                        state_reg  <= ST_ISSUE;
                    end
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (au_done) begin
                        tmp_reg[step_reg] <= au_result;
                        if (step_reg == last_step) begin
                            state_reg <= ST_DONE;
                        end else begin
                            step_reg  <= step_reg + 3'd1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid || m_tready) begin
                        alt_reg   <= alt_next;
                        vel_reg   <= vel_next;
                        p00_reg   <= p00_next;
                        p01_reg   <= p01_next;
                        p11_reg   <= p11_next;
                        out_reg   <= {o32(p11_next), o32(p01_next), o32(p00_next),
                                      o32(vel_next), o32(alt_next)};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_ISSUE))
        else $error("accepted transaction did not start the sequencer");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the commit state");

    a_unit_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        au_done |-> (state_reg == ST_WAIT))
        else $error("arithmetic unit finished with nothing pending");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid && !m_tready) |=> (state_reg == ST_DONE))
        else $error("new result overwrote an untaken transaction");

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for the two-state altitude Kalman filter: directed table, then random
// predict/update traffic with random stalls, checked field by field against a local predictor.
// Depends on akf_pkg and altitude_kalman_filter_2state.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] var_vel;
        logic [31:0] cov_alt_vel;
        logic [31:0] var_alt;
        logic [31:0] velocity;
        logic [31:0] altitude;
    } estimate_t;

    typedef struct {
        logic        mode;
        logic [20:0] dt;
        logic [31:0] accel;
        logic [31:0] range_m;
        bit          known;
        estimate_t   want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0, s_tready;
    logic [akf_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid, m_tready = 1'b0;
    logic [akf_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0, cfg_ready;
    logic cfg_index = 1'b0;
    logic [akf_pkg::NOISE_W-1:0] cfg_data = '0;

    altitude_kalman_filter_2state dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    longint alt_q, vel_q, p00_q, p01_q, p11_q;
    longint proc_q, meas_q;
    estimate_t expected_q[$];
    int mismatches = 0, n_items = 0, n_results = 0, n_pred = 0, n_upd = 0;
    bit calm = 0;
    longint cycles = 0;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    function automatic longint clamp(longint v);
        return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
    endfunction

    function automatic longint lim_sgn(logic [127:0] m, bit neg);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic [127:0] p;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        p = (p + 128'd32768) >> 16;
        return lim_sgn(p, neg);
    endfunction

    function automatic longint qdiv(longint n, longint d);
        logic [127:0] q;
        bit neg;
        if (d == 0) return 0;
        neg = (n < 0) != (d < 0);
        q = (128'(n < 0 ? -n : n) << 16) / 128'(d < 0 ? -d : d);
        return lim_sgn(q, neg);
    endfunction

    function automatic estimate_t filter_step(logic mode, logic [20:0] dt_i,
                                              logic [31:0] acc_i, logic [31:0] z_i);
        longint dt, a, t, n00, n01, n11, den, k0, k1, e;
        estimate_t r;
        if (mode == akf_pkg::MODE_PREDICT) begin
            dt = longint'(dt_i);
            a = longint'(signed'(acc_i));
            t = qmul(dt, p11_q);
            n00 = clamp(p00_q + 2 * qmul(dt, p01_q) + qmul(dt, t) + proc_q);
            alt_q = clamp(alt_q + qmul(dt, vel_q) + qmul(64'sd32768, qmul(qmul(dt, dt), a)));
            vel_q = clamp(vel_q + qmul(dt, a));
            p01_q = clamp(p01_q + t);
            p11_q = clamp(p11_q + proc_q);
            p00_q = n00;
        end else begin
            den = p00_q + meas_q;
            k0 = qdiv(p00_q, den);
            k1 = qdiv(p01_q, den);
            e = longint'(signed'(z_i)) - alt_q;
            alt_q = clamp(alt_q + qmul(k0, e));
            vel_q = clamp(vel_q + qmul(k1, e));
            n00 = clamp(p00_q - qmul(k0, p00_q));
            n01 = clamp(p01_q - qmul(k0, p01_q));
            n11 = clamp(p11_q - qmul(k1, p01_q));
            p00_q = n00;
            p01_q = n01;
            p11_q = n11;
        end
        r.altitude = alt_q[31:0];
        r.velocity = vel_q[31:0];
        r.var_alt = p00_q[31:0];
        r.cov_alt_vel = p01_q[31:0];
        r.var_vel = p11_q[31:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s at result %0d: expected %h, got %h", what, n_results,
                     want, got);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn)
            m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 11);
        if (aresetn && m_tvalid && m_tready) begin
            estimate_t got, want;
            got = m_tdata;
            n_results++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = expected_q.pop_front();
                if (got.altitude !== want.altitude)
                    report("altitude", want.altitude, got.altitude);
                if (got.velocity !== want.velocity)
                    report("velocity", want.velocity, got.velocity);
                if (got.var_alt !== want.var_alt)
                    report("var_alt", want.var_alt, got.var_alt);
                if (got.cov_alt_vel !== want.cov_alt_vel)
                    report("cov_alt_vel", want.cov_alt_vel, got.cov_alt_vel);
                if (got.var_vel !== want.var_vel)
                    report("var_vel", want.var_vel, got.var_vel);
            end
        end
    end

    task automatic write_noise(logic idx, logic [akf_pkg::NOISE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == akf_pkg::CFG_PROC_NOISE) proc_q = longint'(val);
        else meas_q = longint'(val);
        @(posedge aclk);
    endtask

    task automatic send_item(row_t r);
        estimate_t pred;
        while (!calm && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.mode;
        s_tdata <= {3'd0, r.range_m, r.accel, r.dt};
        do @(posedge aclk); while (!s_tready);
        pred = filter_step(r.mode, r.dt, r.accel, r.range_m);
        if (r.known && pred !== r.want) begin
            mismatches++;
            if (mismatches <= 10) $display("table row disagrees with predictor");
        end
        expected_q.push_back(pred);
        n_items++;
        if (r.mode == akf_pkg::MODE_PREDICT) n_pred++; else n_upd++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (expected_q.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    function automatic row_t mk(logic m, logic [20:0] dt, logic [31:0] a, logic [31:0] z);
        row_t r;
        r.mode = m; r.dt = dt; r.accel = a; r.range_m = z; r.known = 0; r.want = '0;
        return r;
    endfunction

    function automatic row_t rand_row(bit sane);
        row_t r;
        r = mk(1'($urandom_range(0, 1)), 21'($urandom), $urandom, $urandom);
        if (sane) begin
            r.dt = 21'($urandom_range(0, 6554));
            r.accel = 32'(signed'($urandom_range(0, 40 << 16)) - (20 << 16));
            r.range_m = 32'(signed'($urandom_range(0, 200 << 16)) - (10 << 16));
        end else if ($urandom_range(0, 1)) begin
            r.dt = 21'($urandom_range(0, 1048576));
        end
        return r;
    endfunction

    row_t table_rows[$];

    initial begin
        row_t r;
        alt_q = 0; vel_q = 0; p00_q = 65536; p01_q = 0; p11_q = 65536;
        proc_q = 65536; meas_q = 65536;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero step from reset: only the noise lands on the diagonal
        r = mk(akf_pkg::MODE_PREDICT, 21'd0, 32'd0, 32'd0);
        r.known = 1; r.want = {32'd131072, 32'd0, 32'd131072, 32'd0, 32'd0};
        table_rows.push_back(r);
        table_rows.push_back(mk(akf_pkg::MODE_UPDATE, 21'd0, 32'd0, 32'h7fff_ffff));
        table_rows.push_back(mk(akf_pkg::MODE_UPDATE, 21'h1f_ffff, 32'hffff_ffff,
                                32'h8000_0000));
        table_rows.push_back(mk(akf_pkg::MODE_PREDICT, 21'd65536, 32'h0002_0000,
                                32'hffff_ffff));
        table_rows.push_back(mk(akf_pkg::MODE_PREDICT, 21'd1048576, 32'h7fff_ffff, 32'd0));
        table_rows.push_back(mk(akf_pkg::MODE_PREDICT, 21'h1f_ffff, 32'h8000_0000, 32'd0));
        table_rows.push_back(mk(akf_pkg::MODE_UPDATE, 21'd0, 32'd0, 32'd0));
        table_rows.push_back(mk(akf_pkg::MODE_PREDICT, 21'd1, 32'h8000_0000, 32'd0));
        table_rows.push_back(mk(akf_pkg::MODE_UPDATE, 21'd3, 32'h1234_5678, 32'h0001_0000));
        foreach (table_rows[i]) send_item(table_rows[i]);
        drain();

        // both noises at zero, so the gain denominator is P00 alone
        write_noise(akf_pkg::CFG_PROC_NOISE, '0);
        write_noise(akf_pkg::CFG_MEAS_NOISE, '0);
        table_rows.delete();
        table_rows.push_back(mk(akf_pkg::MODE_UPDATE, 21'd0, 32'd0, 32'h0100_0000));
        table_rows.push_back(mk(akf_pkg::MODE_PREDICT, 21'd32768, 32'h0001_0000, 32'd0));
        table_rows.push_back(mk(akf_pkg::MODE_UPDATE, 21'd0, 32'd0, 32'h0005_0000));
        foreach (table_rows[i]) send_item(table_rows[i]);
        drain();

        write_noise(akf_pkg::CFG_PROC_NOISE, 31'h7fff_ffff);
        write_noise(akf_pkg::CFG_MEAS_NOISE, 31'h7fff_ffff);
        for (int i = 0; i < 6; i++) send_item(rand_row(0));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_noise(akf_pkg::CFG_PROC_NOISE,
                        ph == 3 ? 31'($urandom) : 31'($urandom_range(0, 1 << 17)));
            write_noise(akf_pkg::CFG_MEAS_NOISE,
                        ph == 3 ? 31'($urandom) : 31'($urandom_range(0, 1 << 18)));
            calm = (ph == 1);
            for (int i = 0; i < 150; i++) send_item(rand_row($urandom_range(0, 99) < 80));
            drain();
        end
        calm = 0;

        $display("covered %0d items (%0d predict, %0d update), %0d results checked",
                 n_items, n_pred, n_upd, n_results);
        $display("noise registers swept through zero, small, random and full scale");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        wait (cycles >= 64'd2000000);
        $display("timeout after %0d cycles", cycles);
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

@@ altitude_kalman_filter_2state.f @@
design/akf_pkg.sv
design/akf_arith.sv
design/altitude_kalman_filter_2state.sv
test/tb.sv
